FILE: design/lattice_metropolis_hop_assert.svh
// assertion macros for the lattice hop block
`ifndef LATTICE_METROPOLIS_HOP_ASSERT_SVH
`define LATTICE_METROPOLIS_HOP_ASSERT_SVH
`ifndef SYNTH
`define LMH_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("lattice hop check failed");
`define LMH_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("lattice hop sequencing check failed");
`else
`define LMH_ASSERT_IMP(lbl, a, b)
`define LMH_ASSERT_NXT(lbl, a, b)
`endif
`endif

FILE: design/lmh_pkg.sv
// package for the lattice hop block: constants, codes and tables
`default_nettype none
package lmh_pkg;
	localparam int SIDE_X_DEF = 32;
	localparam int SIDE_Y_DEF = 32;
	localparam int SIDE_Z_DEF = 32;
	localparam int MAX_PARTICLES_DEF = 1024;

	localparam int NUM_DIRS = 12;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	typedef enum logic [2:0] {
		ST_MOVED    = 3'd0,
		ST_HELD     = 3'd1,
		ST_EDGE     = 3'd2,
		ST_OCCUPIED = 3'd3,
		ST_DROPPED  = 3'd4,
		ST_COL_FULL = 3'd5,
		ST_FULL     = 3'd6,
		ST_BAD      = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		REG_EE    = 3'd0,
		REG_EF    = 3'd1,
		REG_FE    = 3'd2,
		REG_FF    = 3'd3,
		REG_BETA  = 3'd4,
		REG_SUBST = 3'd5,
		REG_NONE6 = 3'd6,
		REG_NONE7 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
		logic signed [1:0] dz;
	} offset_t;

	// 2^(-i/16) in q1.16, one extra entry for interpolation
	function automatic logic [16:0] pow_tab(input logic [4:0] k);
		logic [16:0] v;
		unique case (k)
			5'd0: v = 17'd65536;
			5'd1: v = 17'd62757;
			5'd2: v = 17'd60097;
			5'd3: v = 17'd57549;
			5'd4: v = 17'd55109;
			5'd5: v = 17'd52773;
			5'd6: v = 17'd50535;
			5'd7: v = 17'd48393;
			5'd8: v = 17'd46341;
			5'd9: v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

	// striped neighbor offsets, inter-layer ones shifted down one in x and y on even layers
	function automatic offset_t nb_offset(input logic [3:0] dir, input logic z_odd);
		offset_t o;
		unique case (dir)
			4'd0: o = '{dx: 2'sd1, dy: 2'sd0, dz: 2'sd0};
			4'd1: o = '{dx: -2'sd1, dy: 2'sd0, dz: 2'sd0};
			4'd2: o = '{dx: 2'sd0, dy: 2'sd1, dz: 2'sd0};
			4'd3: o = '{dx: 2'sd0, dy: -2'sd1, dz: 2'sd0};
			4'd4: o = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd1};
			4'd5: o = '{dx: 2'sd1, dy: 2'sd0, dz: 2'sd1};
			4'd6: o = '{dx: 2'sd1, dy: 2'sd1, dz: 2'sd1};
			4'd7: o = '{dx: 2'sd0, dy: 2'sd1, dz: 2'sd1};
			4'd8: o = '{dx: 2'sd0, dy: 2'sd0, dz: -2'sd1};
			4'd9: o = '{dx: 2'sd1, dy: 2'sd0, dz: -2'sd1};
			4'd10: o = '{dx: 2'sd1, dy: 2'sd1, dz: -2'sd1};
			4'd11: o = '{dx: 2'sd0, dy: 2'sd1, dz: -2'sd1};
			default: o = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
		endcase
		if (!z_odd && o.dz != 2'sd0) begin
			o.dx = o.dx - 2'sd1;
			o.dy = o.dy - 2'sd1;
		end
		return o;
	endfunction
endpackage
`default_nettype wire

FILE: design/lattice_metropolis_hop.sv
// lattice hop block: site store, particle table and metropolis sequencer
// after reset the site memory is swept clear with busy high
// an evaluated hop reads the position, checks target and site, clears the old site, makes
// the 24 neighbor reads on the single site port, runs the shared unit, decides and shows
// a drop checks the top site, then each layer down, and places; refusals end at their check
// the next transfer may come at the edge that takes the result; done high one cycle, no stall
`default_nettype none
`include "lattice_metropolis_hop_assert.svh"
module lattice_metropolis_hop #(
	parameter int SIDE_X = lmh_pkg::SIDE_X_DEF,
	parameter int SIDE_Y = lmh_pkg::SIDE_Y_DEF,
	parameter int SIDE_Z = lmh_pkg::SIDE_Z_DEF,
	parameter int MAX_PARTICLES = lmh_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [9:0]  particle,
	input  wire logic [3:0]  direction,
	input  wire logic [15:0] chance,
	input  wire logic [4:0]  drop_x,
	input  wire logic [4:0]  drop_y,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [10:0]      count,
	output logic [4:0]       pos_x,
	output logic [4:0]       pos_y,
	output logic [4:0]       pos_z,
	output logic signed [23:0] energy_change
);
	localparam int SMAX = (SIDE_X > SIDE_Y) ? ((SIDE_X > SIDE_Z) ? SIDE_X : SIDE_Z)
		: ((SIDE_Y > SIDE_Z) ? SIDE_Y : SIDE_Z);
	localparam int CW = $clog2(SMAX);
	localparam int SW = CW + 2;
	localparam int NSITES = SIDE_X * SIDE_Y * SIDE_Z;
	localparam int AW = $clog2(NSITES);
	localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int NW = $clog2(MAX_PARTICLES + 1);
	localparam int NBW = 5;
	localparam logic signed [SW-1:0] LIM_X = SW'(SIDE_X - 1);
	localparam logic signed [SW-1:0] LIM_Y = SW'(SIDE_Y - 1);
	localparam logic signed [SW-1:0] LIM_Z = SW'(SIDE_Z - 1);
	localparam logic signed [SW-1:0] SX_S = SW'(SIDE_X);
	localparam logic signed [SW-1:0] SY_S = SW'(SIDE_Y);
	localparam logic signed [SW-1:0] SZ_S = SW'(SIDE_Z);
	localparam logic [CW-1:0] Z_TOP = CW'(SIDE_Z - 2);
	localparam logic [NBW-1:0] NB_LAST = NBW'(2 * lmh_pkg::NUM_DIRS);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE,
		S_D_TOP_RD, S_D_TOP_CK, S_D_FALL_RD, S_D_FALL_CK, S_D_PLACE,
		S_H_POS, S_H_TGT, S_H_OCC_RD, S_H_OCC_CK, S_H_CLR, S_H_NB,
		S_H_EXP0, S_H_EXP1, S_H_EXP2, S_H_EXP3, S_H_DEC
	} state_t;

	state_t state_q;
	logic [15:0] regs_q [6];
	logic [AW-1:0] clr_q;
	logic [NW-1:0] cnt_q;
	logic [PW-1:0] part_q;
	logic [3:0] dir_q;
	logic [15:0] chance_q;
	logic [CW-1:0] cx_q, cy_q, z_q;
	logic [CW-1:0] hx_q, hy_q, hz_q;
	logic [NBW-1:0] nb_q;
	logic vld_s1, inlat_s1, sub_s1, neg_s1;
	logic signed [23:0] de_q;
	logic [39:0] mag_q;
	logic [20:0] y_q;
	logic [3:0] k_q;
	logic [4:0] n_q;
	logic [11:0] frac_q;
	logic acc_q;

	// site memory, one occupancy bit per site
	logic site_mem [NSITES];
	logic [AW-1:0] site_addr;
	logic site_we, site_wd, site_rd_q;

	// particle position memory
	logic [3*CW-1:0] pos_mem [MAX_PARTICLES];
	logic [PW-1:0] pos_addr;
	logic pos_we;
	logic [3*CW-1:0] pos_wd, pos_rd_q;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
		input logic [CW-1:0] z);
		return AW'((32'(x) * SIDE_Y + 32'(y)) * SIDE_Z + 32'(z));
	endfunction

	// neighbor generation
	logic nb_new;
	logic [3:0] nb_dir;
	logic [CW-1:0] bx, by, bz;
	lmh_pkg::offset_t nb_off;
	logic signed [SW-1:0] nx, ny, nz;
	logic nb_inlat;

	always_comb begin
		nb_new = (nb_q < NBW'(lmh_pkg::NUM_DIRS));
		nb_dir = nb_new ? nb_q[3:0] : 4'(nb_q - NBW'(lmh_pkg::NUM_DIRS));
		bx = nb_new ? hx_q : cx_q;
		by = nb_new ? hy_q : cy_q;
		bz = nb_new ? hz_q : z_q;
		nb_off = lmh_pkg::nb_offset(nb_dir, bz[0]);
		nx = $signed({2'b00, bx}) + SW'(nb_off.dx);
		ny = $signed({2'b00, by}) + SW'(nb_off.dy);
		nz = $signed({2'b00, bz}) + SW'(nb_off.dz);
		nb_inlat = (nx >= 0) && (nx < SX_S) && (ny >= 0) && (ny < SY_S)
			&& (nz >= 0) && (nz < SZ_S);
	end

	// hop target from the stored position
	lmh_pkg::offset_t tgt_off;
	logic signed [SW-1:0] tx, ty, tz;
	logic tgt_edge;

	always_comb begin
		tgt_off = lmh_pkg::nb_offset(dir_q, pos_rd_q[0]);
		tx = $signed({2'b00, pos_rd_q[3*CW-1:2*CW]}) + SW'(tgt_off.dx);
		ty = $signed({2'b00, pos_rd_q[2*CW-1:CW]}) + SW'(tgt_off.dy);
		tz = $signed({2'b00, pos_rd_q[CW-1:0]}) + SW'(tgt_off.dz);
		tgt_edge = (tx <= 0) || (tx >= LIM_X) || (ty <= 0) || (ty >= LIM_Y)
			|| (tz <= 0) || (tz >= LIM_Z);
	end

	// energy term of the neighbor read last cycle
	logic nb_occ;
	logic signed [17:0] pdiff;
	logic signed [23:0] term;

	always_comb begin
		nb_occ = site_rd_q & inlat_s1;
		pdiff = nb_occ
			? (18'($signed(regs_q[lmh_pkg::REG_FF])) - 18'($signed(regs_q[lmh_pkg::REG_EF])))
			: (18'($signed(regs_q[lmh_pkg::REG_FE])) - 18'($signed(regs_q[lmh_pkg::REG_EE])));
		term = 24'(pdiff) + (sub_s1 ? {8'd0, regs_q[lmh_pkg::REG_SUBST]} : 24'd0);
	end

	// shared arithmetic for the acceptance test
	logic [23:0] de_mag;
	logic [36:0] y_prod;
	logic [16:0] t_lo, t_hi, t_diff;
	logic [23:0] frac_prod;
	logic [16:0] v_val, w_val;

	always_comb begin
		de_mag = 24'(-de_q);
		y_prod = 37'(mag_q[19:0]) * 37'(lmh_pkg::LOG2E_Q16);
		t_lo = lmh_pkg::pow_tab({1'b0, y_q[15:12]});
		t_hi = lmh_pkg::pow_tab(5'({1'b0, y_q[15:12]}) + 5'd1);
		t_diff = t_lo - t_hi;
		frac_prod = 24'(t_diff[11:0]) * 24'(y_q[11:0]);
		v_val = lmh_pkg::pow_tab({1'b0, k_q}) - 17'(frac_q);
		w_val = v_val >> n_q;
	end

	// memory port control
	always_comb begin
		site_addr = addr_of(nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]);
		site_we = 1'b0;
		site_wd = 1'b0;
		pos_addr = part_q;
		pos_we = 1'b0;
		pos_wd = {hx_q, hy_q, hz_q};
		unique case (state_q)
			S_CLEAR: begin
				site_addr = clr_q;
				site_we = 1'b1;
			end
			S_D_TOP_RD, S_D_FALL_RD: site_addr = addr_of(cx_q, cy_q, z_q);
			S_D_PLACE: begin
				site_addr = addr_of(cx_q, cy_q, z_q);
				site_we = 1'b1;
				site_wd = 1'b1;
				pos_addr = PW'(cnt_q);
				pos_we = 1'b1;
				pos_wd = {cx_q, cy_q, z_q};
			end
			S_H_OCC_RD: site_addr = addr_of(hx_q, hy_q, hz_q);
			S_H_CLR: begin
				site_addr = addr_of(cx_q, cy_q, z_q);
				site_we = 1'b1;
			end
			S_H_DEC: begin
				site_we = 1'b1;
				site_wd = 1'b1;
				if (acc_q) begin
					site_addr = addr_of(hx_q, hy_q, hz_q);
					pos_we = 1'b1;
				end else begin
					site_addr = addr_of(cx_q, cy_q, z_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (site_we) begin
			site_mem[site_addr] <= site_wd;
		end
		site_rd_q <= site_mem[site_addr];
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_addr] <= pos_wd;
		end
		pos_rd_q <= pos_mem[pos_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[lmh_pkg::REG_EE] <= 16'd0;
			regs_q[lmh_pkg::REG_EF] <= 16'd0;
			regs_q[lmh_pkg::REG_FE] <= 16'd0;
			regs_q[lmh_pkg::REG_FF] <= 16'd256;
			regs_q[lmh_pkg::REG_BETA] <= 16'd256;
			regs_q[lmh_pkg::REG_SUBST] <= 16'd25600;
		end else if (cfg_we && cfg_index != lmh_pkg::REG_NONE6
			&& cfg_index != lmh_pkg::REG_NONE7) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
			status <= lmh_pkg::ST_MOVED;
			count <= '0;
			pos_x <= '0;
			pos_y <= '0;
			pos_z <= '0;
			energy_change <= '0;
			part_q <= '0;
			dir_q <= '0;
			chance_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			z_q <= '0;
			hx_q <= '0;
			hy_q <= '0;
			hz_q <= '0;
			nb_q <= '0;
			vld_s1 <= 1'b0;
			inlat_s1 <= 1'b0;
			sub_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			de_q <= '0;
			mag_q <= '0;
			y_q <= '0;
			k_q <= '0;
			n_q <= '0;
			frac_q <= '0;
			acc_q <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NSITES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						part_q <= PW'(particle);
						dir_q <= direction;
						chance_q <= chance;
						cx_q <= CW'(drop_x);
						cy_q <= CW'(drop_y);
						z_q <= Z_TOP;
						status <= lmh_pkg::ST_BAD;
						count <= 11'(cnt_q);
						pos_x <= '0;
						pos_y <= '0;
						pos_z <= '0;
						energy_change <= '0;
						if (mode) begin
							if (cnt_q >= NW'(MAX_PARTICLES)) begin
								status <= lmh_pkg::ST_FULL;
								done <= 1'b1;
							end else if (32'(drop_x) >= SIDE_X || 32'(drop_y) >= SIDE_Y) begin
								done <= 1'b1;
							end else begin
								state_q <= S_D_TOP_RD;
							end
						end else if (32'(particle) >= 32'(cnt_q)
							|| 32'(particle) >= MAX_PARTICLES
							|| direction >= 4'(lmh_pkg::NUM_DIRS)) begin
							done <= 1'b1;
						end else begin
							state_q <= S_H_POS;
						end
					end
				end
				S_D_TOP_RD: state_q <= S_D_TOP_CK;
				S_D_TOP_CK: begin
					if (site_rd_q) begin
						status <= lmh_pkg::ST_COL_FULL;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						z_q <= z_q - CW'(1);
						state_q <= S_D_FALL_RD;
					end
				end
				S_D_FALL_RD: begin
					if (z_q == '0) begin
						z_q <= CW'(1);
						state_q <= S_D_PLACE;
					end else begin
						state_q <= S_D_FALL_CK;
					end
				end
				S_D_FALL_CK: begin
					if (site_rd_q) begin
						z_q <= z_q + CW'(1);
						state_q <= S_D_PLACE;
					end else begin
						z_q <= z_q - CW'(1);
						state_q <= S_D_FALL_RD;
					end
				end
				S_D_PLACE: begin
					cnt_q <= cnt_q + NW'(1);
					status <= lmh_pkg::ST_DROPPED;
					count <= 11'(cnt_q + NW'(1));
					pos_x <= 5'(cx_q);
					pos_y <= 5'(cy_q);
					pos_z <= 5'(z_q);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_H_POS: state_q <= S_H_TGT;
				S_H_TGT: begin
					cx_q <= pos_rd_q[3*CW-1:2*CW];
					cy_q <= pos_rd_q[2*CW-1:CW];
					z_q <= pos_rd_q[CW-1:0];
					hx_q <= tx[CW-1:0];
					hy_q <= ty[CW-1:0];
					hz_q <= tz[CW-1:0];
					if (tgt_edge) begin
						status <= lmh_pkg::ST_EDGE;
						pos_x <= 5'(pos_rd_q[3*CW-1:2*CW]);
						pos_y <= 5'(pos_rd_q[2*CW-1:CW]);
						pos_z <= 5'(pos_rd_q[CW-1:0]);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_H_OCC_RD;
					end
				end
				S_H_OCC_RD: state_q <= S_H_OCC_CK;
				S_H_OCC_CK: begin
					if (site_rd_q) begin
						status <= lmh_pkg::ST_OCCUPIED;
						pos_x <= 5'(cx_q);
						pos_y <= 5'(cy_q);
						pos_z <= 5'(z_q);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_H_CLR;
					end
				end
				S_H_CLR: begin
					nb_q <= '0;
					de_q <= '0;
					state_q <= S_H_NB;
				end
				S_H_NB: begin
					if (vld_s1) begin
						de_q <= neg_s1 ? (de_q - term) : (de_q + term);
					end
					if (nb_q == NB_LAST) begin
						state_q <= S_H_EXP0;
					end else begin
						vld_s1 <= 1'b1;
						inlat_s1 <= nb_inlat;
						sub_s1 <= (nz == 0);
						neg_s1 <= !nb_new;
						nb_q <= nb_q + NBW'(1);
					end
				end
				S_H_EXP0: begin
					if (de_q > 0) begin
						acc_q <= 1'b1;
						state_q <= S_H_DEC;
					end else begin
						mag_q <= 40'(de_mag) * 40'(regs_q[lmh_pkg::REG_BETA]);
						state_q <= S_H_EXP1;
					end
				end
				S_H_EXP1: begin
					if (mag_q[39:20] != '0) begin
						acc_q <= 1'b0;
						state_q <= S_H_DEC;
					end else begin
						y_q <= y_prod[36:16];
						state_q <= S_H_EXP2;
					end
				end
				S_H_EXP2: begin
					if (y_q[20:16] > 5'd16) begin
						acc_q <= 1'b0;
						state_q <= S_H_DEC;
					end else begin
						k_q <= y_q[15:12];
						n_q <= y_q[20:16];
						frac_q <= frac_prod[23:12];
						state_q <= S_H_EXP3;
					end
				end
				S_H_EXP3: begin
					acc_q <= (w_val > 17'(chance_q));
					state_q <= S_H_DEC;
				end
				S_H_DEC: begin
					energy_change <= de_q;
					if (acc_q) begin
						status <= lmh_pkg::ST_MOVED;
						pos_x <= 5'(hx_q);
						pos_y <= 5'(hy_q);
						pos_z <= 5'(hz_q);
					end else begin
						status <= lmh_pkg::ST_HELD;
						pos_x <= 5'(cx_q);
						pos_y <= 5'(cy_q);
						pos_z <= 5'(z_q);
					end
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LMH_ASSERT_IMP(a_energy_only_evaluated, done && status != lmh_pkg::ST_MOVED && status != lmh_pkg::ST_HELD, energy_change == '0)
	`LMH_ASSERT_IMP(a_refused_no_pos, done && (status == lmh_pkg::ST_BAD || status == lmh_pkg::ST_FULL || status == lmh_pkg::ST_COL_FULL), pos_x == '0 && pos_y == '0 && pos_z == '0)
	`LMH_ASSERT_IMP(a_count_moves_on_drop, cnt_q != $past(cnt_q), done && status == lmh_pkg::ST_DROPPED)
	`LMH_ASSERT_NXT(a_clear_then_sum, state_q == S_H_CLR, state_q == S_H_NB && de_q == '0)
	`LMH_ASSERT_IMP(a_busy_while_clear, state_q == S_CLEAR, busy && !done)
endmodule
`default_nettype wire
